// ===== rtl/core/dlaq_pkg.sv =====
// Shared constants and controller/datapath interface types for the delta-list alarm queue.
package dlaq_pkg;

  localparam int MAX_ALARMS = 16;
  localparam int DELAY_W    = 24;
  localparam int HANDLE_W   = 8;
  localparam int IDX_W      = $clog2(MAX_ALARMS);
  localparam int CNT_W      = $clog2(MAX_ALARMS + 1);

  localparam int S_TDATA_W  = 32;
  localparam int M_TDATA_W  = 16;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic KIND_FIRE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // latch insert request, clear walk
    logic tick_dec;   // decrement head delta
    logic walk_step;  // add current delta to running sum, advance index
    logic place;      // shift tail up and write new entry at index
    logic pop_emit;   // report head as fired and pop it
    logic ack_emit;   // report insert acknowledgement
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic head_zero;
    logic found;      // insert position reached at current index
    logic fire_last;  // popping the head ends the firing run
    logic out_free;   // output register can take a beat this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/dlaq_datapath.sv =====
// Alarm list storage, insert walk, pop/shift logic and the output register.
module dlaq_datapath import dlaq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] delay_ticks, [31:24] alarm_handle
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] fired_handle, [8] rejected, rest zero
  output logic                 m_tuser,   // [0] kind
  output logic                 m_tlast
);

  logic [DELAY_W-1:0]  dly [MAX_ALARMS];
  logic [HANDLE_W-1:0] hdl [MAX_ALARMS];
  logic [CNT_W-1:0]    count;
  logic [DELAY_W-1:0]  req_dly;
  logic [HANDLE_W-1:0] req_hdl;
  logic                rej;
  logic [DELAY_W-1:0]  sum;
  logic [IDX_W-1:0]    idx;

  logic [HANDLE_W-1:0] out_hdl;
  logic                out_rej;
  logic                out_kind;
  logic                out_last;

  logic [DELAY_W-1:0]  cur_dly;
  logic [DELAY_W:0]    run_sum;
  logic [DELAY_W-1:0]  delta;
  logic [CNT_W-1:0]    idx_ext;

  // Walk arithmetic on the entry under the index
  assign cur_dly = dly[idx];
  assign run_sum = {1'b0, sum} + {1'b0, cur_dly};
  assign delta   = req_dly - sum;
  assign idx_ext = CNT_W'(idx);

  assign stat.empty     = (count == '0);
  assign stat.full      = (count == CNT_W'(MAX_ALARMS));
  assign stat.head_zero = (dly[0] == '0);
  assign stat.found     = (idx_ext == count) || (run_sum >= {1'b0, req_dly});
  assign stat.fire_last = (count == CNT_W'(1)) || (dly[1] != '0);
  assign stat.out_free  = !m_tvalid || m_tready;

  // Entry storage: insert shifts the tail up, pop shifts everything down
  always_ff @(posedge clk) begin
    if (cmd.place) begin
      for (int j = 1; j < MAX_ALARMS; j++) begin
        if ((CNT_W'(j) > idx_ext) && (CNT_W'(j) <= count)) begin
          hdl[j] <= hdl[j-1];
          if (CNT_W'(j) == idx_ext + CNT_W'(1)) begin
            dly[j] <= dly[j-1] - delta;
          end else begin
            dly[j] <= dly[j-1];
          end
        end
      end
      dly[idx] <= delta;
      hdl[idx] <= req_hdl;
    end else if (cmd.pop_emit) begin
      for (int j = 0; j < MAX_ALARMS - 1; j++) begin
        dly[j] <= dly[j+1];
        hdl[j] <= hdl[j+1];
      end
    end else if (cmd.tick_dec) begin
      dly[0] <= dly[0] - DELAY_W'(1);
    end
  end

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.place) begin
      count <= count + CNT_W'(1);
    end else if (cmd.pop_emit) begin
      count <= count - CNT_W'(1);
    end
  end

  // Request latch and running sum of the walk
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_dly <= s_tdata[DELAY_W-1:0];
      req_hdl <= s_tdata[DELAY_W +: HANDLE_W];
      rej     <= stat.full;
      sum     <= '0;
      idx     <= '0;
    end else if (cmd.walk_step) begin
      sum <= run_sum[DELAY_W-1:0];
      idx <= idx + IDX_W'(1);
    end
  end

  // Output register: holds a beat until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.pop_emit || cmd.ack_emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_emit) begin
      out_kind <= KIND_FIRE;
      out_hdl  <= hdl[0];
      out_rej  <= 1'b0;
      out_last <= stat.fire_last;
    end else if (cmd.ack_emit) begin
      out_kind <= KIND_ACK;
      out_hdl  <= '0;
      out_rej  <= rej;
      out_last <= 1'b1;
    end
  end

  assign m_tdata = {{(M_TDATA_W - HANDLE_W - 1){1'b0}}, out_rej, out_hdl};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ALARMS))
    else $error("entry count above capacity");

  a_place_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> !stat.full)
    else $error("insert placed into a full list");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop_emit |-> !stat.empty && stat.out_free)
    else $error("pop from empty list or onto a busy output");

  a_place_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.place |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the list by one");

  a_ack_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ack_emit |-> stat.out_free)
    else $error("acknowledgement overwrote a pending beat");
`endif

endmodule

// ===== rtl/core/dlaq_ctrl.sv =====
// Sequencer for tick, insert walk, acknowledgement and fire runs.
module dlaq_ctrl import dlaq_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  logic     opcode,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_ACK,
    S_FIRE
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  // Next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (opcode == OP_INSERT) begin
            cmd.load   = 1'b1;
            state_next = stat.full ? S_ACK : S_WALK;
          end else if (!stat.empty) begin
            if (stat.head_zero) begin
              state_next = S_FIRE;
            end else begin
              cmd.tick_dec = 1'b1;
            end
          end
        end
      end
      S_WALK: begin
        if (stat.found) begin
          cmd.place  = 1'b1;
          state_next = S_ACK;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      S_ACK: begin
        if (stat.out_free) begin
          cmd.ack_emit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_FIRE: begin
        if (stat.out_free) begin
          cmd.pop_emit = 1'b1;
          if (stat.fire_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== rtl/core/delta_list_alarm_queue_unit.sv =====
// Top level of the delta-list alarm queue: stream ports, sequencer and datapath.
//
// Keeps up to MAX_ALARMS (16) alarms as a list of delays relative to the
// previous entry. A tick beat (tuser 0) on an empty list or on a nonzero head
// returns nothing; on a zero head it fires the head and each following zero
// entry, one output beat per alarm (tlast on the final one), each beat waiting
// while the output register is busy. An insert beat (tuser 1) walks the list
// one entry per cycle through a single running-sum adder; the acknowledgement
// beat has tuser 1 and rejected set when the list was full. Input is taken
// only between items; a finished beat may wait in the output register while
// the next item is accepted.
module delta_list_alarm_queue_unit import dlaq_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [23:0] delay_ticks, [31:24] alarm_handle
  input  logic                 s_tuser,   // [0] opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [7:0] fired_handle, [8] rejected, [15:9] zero
  output logic                 m_tuser,   // [0] kind
  output logic                 m_tlast
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dlaq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .opcode   (s_tuser),
    .stat     (stat),
    .cmd      (cmd)
  );

  dlaq_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
